[design/sida_pkg.sv]
package sida_pkg;

	// Character codes and radix.
	localparam logic [7:0] CharMinus = 8'd45;
	localparam logic [7:0] CharZero = 8'd48;
	localparam logic [3:0] Radix = 4'd10;

	// A 32-bit magnitude has at most ten decimal digits.
	localparam int MaxDigits = 10;
	localparam int IdxW = 4;

	// Reciprocal of ten scaled by 2^35; exact for every 32-bit dividend.
	localparam logic [31:0] RecipTen = 32'hCCCC_CCCD;
	localparam int RecipShift = 35;

	typedef logic [3:0] digit_t;
	typedef logic [IdxW-1:0] idx_t;

	// Quotient and remainder from the divide-by-ten unit.
	typedef struct packed {
		logic [31:0] quot;
		digit_t rem;
	} div_res_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIVIDE,
		ST_EMIT
	} state_t;

endpackage

[design/sida_div10.sv]
module sida_div10
	import sida_pkg::*;
(
	input logic [31:0] dividend,
	output div_res_t result
);

	logic [63:0] prod;
	logic [31:0] quot;
	logic [31:0] quot_x10;
	logic [31:0] rem_full;

	// Quotient by multiplication with the scaled reciprocal of ten.
	assign prod = {32'd0, dividend} * {32'd0, RecipTen};
	assign quot = {{RecipShift - 32{1'b0}}, prod[63:RecipShift]};

	// Remainder is the dividend less ten times the quotient.
	assign quot_x10 = (quot << 3) + (quot << 1);
	assign rem_full = dividend - quot_x10;

	assign result.quot = quot;
	assign result.rem = rem_full[3:0];

endmodule

[design/signed_int_to_decimal_ascii_top.sv]
// Converts one signed 32-bit integer per request into ASCII decimal characters.
// Digits are extracted through the shared divide-by-ten unit, then characters
// are offered one per cycle while out_ready is high. No new request is taken
// (in_ready stays low) until the last character of the current one is accepted.
// Reset (arst_n low) returns to idle.
module signed_int_to_decimal_ascii_top
	import sida_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic signed [31:0] number,
	output logic out_valid,
	input logic out_ready,
	output logic [7:0] ascii_char,
	output logic last_char
);

	state_t state_q;
	state_t state_d;
	logic [31:0] mag_q;
	logic sign_q;
	idx_t cnt_q;
	idx_t idx_q;
	digit_t digs_q [MaxDigits];
	div_res_t div_res;
	logic div_done;
	logic in_acc;
	logic out_acc;

	assign in_acc = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	// Shared divide-by-ten unit, one digit per cycle.
	sida_div10 u_div10 (
		.dividend(mag_q),
		.result(div_res)
	);

	assign div_done = (div_res.quot == 32'd0) || (cnt_q == idx_t'(MaxDigits - 1));

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					state_d = ST_DIVIDE;
				end
			end
			ST_DIVIDE: begin
				if (div_done) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (out_acc && !sign_q && (idx_q == idx_t'(0))) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Output logic: the sign goes first, then digits from the most significant.
	always_comb begin
		in_ready = 1'b0;
		out_valid = 1'b0;
		ascii_char = CharZero;
		last_char = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
			end
			ST_DIVIDE: begin
				in_ready = 1'b0;
			end
			ST_EMIT: begin
				out_valid = 1'b1;
				if (sign_q) begin
					ascii_char = CharMinus;
				end else begin
					ascii_char = CharZero + {4'd0, digs_q[idx_q]};
					last_char = (idx_q == idx_t'(0));
				end
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sign_q <= 1'b0;
			cnt_q <= '0;
			idx_q <= '0;
		end else begin
			state_q <= state_d;
			if (in_acc) begin
				sign_q <= number[31];
				cnt_q <= '0;
			end else if (state_q == ST_DIVIDE) begin
				cnt_q <= cnt_q + idx_t'(1);
				if (div_done) begin
					idx_q <= cnt_q;
				end
			end else if (out_acc) begin
				if (sign_q) begin
					sign_q <= 1'b0;
				end else if (idx_q != idx_t'(0)) begin
					idx_q <= idx_q - idx_t'(1);
				end
			end
		end
	end

	// Magnitude and digit store; the least significant digit lands at index zero.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			mag_q <= number[31] ? (32'd0 - unsigned'(number)) : unsigned'(number);
		end else if (state_q == ST_DIVIDE) begin
			mag_q <= div_res.quot;
			digs_q[cnt_q] <= div_res.rem;
		end
	end

`ifndef ASSERT_OFF
	// No new request is taken while characters are being offered.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("input accepted during character output");

	// An accepted request always starts digit extraction.
	a_start_divide: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (state_q == ST_DIVIDE))
		else $error("accepted request did not start division");

	// A minus sign is never the final character.
	a_sign_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && sign_q) |-> !last_char)
		else $error("minus sign marked as last character");

	// Digit characters stay within the decimal range.
	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !sign_q) |-> (ascii_char >= CharZero
			&& ascii_char < CharZero + {4'd0, Radix}))
		else $error("digit character out of range");

	// The digit index never passes the highest digit slot.
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (idx_q < idx_t'(MaxDigits)))
		else $error("digit index out of range");
`endif

endmodule
